@@ hdl/slcd_pkg.sv @@
package slcd_pkg;

   localparam int NUM_WORDS  = 8;
   localparam int NUM_DIGITS = 6;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_LC_D  = 8'h64;
   localparam logic [7:0] CHAR_LC_M  = 8'h6D;
   localparam logic [7:0] CHAR_LC_N  = 8'h6E;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_LPAR  = 8'h28;
   localparam logic [7:0] CHAR_RPAR  = 8'h29;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_MICRO = 8'hB5;
   localparam logic [7:0] CHAR_DEG   = 8'hB0;
   localparam logic [7:0] CHAR_ALL   = 8'hFF;

   localparam logic [15:0] POINT_SEG = 16'h0002;
   localparam logic [15:0] COLON_SEG = 16'h0020;

   localparam logic [2:0] BAR_WORD_A = 3'd6;
   localparam logic [2:0] BAR_WORD_B = 3'd4;
   localparam int         BAR_BIT_LO = 8;
   localparam int         BAR_BIT_HI = 25;

   localparam logic [15:0] LETTER_CODES [26] = '{
      16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
      16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
      16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
      16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
   };

   localparam logic [15:0] DIGIT_CODES [10] = '{
      16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
      16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
   };

   // word offset and bit number for each position and nibble bit
   localparam logic PIN_WORD [NUM_DIGITS][4] = '{
      '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b0}
   };

   localparam logic [4:0] PIN_BIT [NUM_DIGITS][4] = '{
      '{5'd4,  5'd23, 5'd22, 5'd3},  '{5'd6,  5'd13, 5'd12, 5'd5},
      '{5'd15, 5'd29, 5'd28, 5'd14}, '{5'd31, 5'd1,  5'd0,  5'd30},
      '{5'd3,  5'd25, 5'd24, 5'd2},  '{5'd17, 5'd8,  5'd9,  5'd26}
   };

   typedef logic [NUM_WORDS-1:0][31:0] frame_type;

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
   } item_type;

   function automatic logic [15:0] encode_byte(input logic [7:0] c);
      logic [7:0]  d;
      logic [15:0] code;
      begin
         d    = 8'd0;
         code = 16'h0000;
         unique case (c)
            CHAR_LC_D:  code = 16'hF300;
            CHAR_LC_M:  code = 16'hB210;
            CHAR_LC_N:  code = 16'h2210;
            CHAR_STAR:  code = 16'hA0DD;
            CHAR_LPAR:  code = 16'h0028;
            CHAR_RPAR:  code = 16'h0011;
            CHAR_MINUS: code = 16'hA000;
            CHAR_PLUS:  code = 16'hA014;
            CHAR_SLASH: code = 16'h00C0;
            CHAR_PCT:   code = 16'hB300;
            CHAR_MICRO: code = 16'h6084;
            CHAR_DEG:   code = 16'hEC00;
            CHAR_ALL:   code = 16'hFFDD;
            default: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  d    = c - CHAR_ZERO;
                  code = DIGIT_CODES[d[3:0]];
               end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
                  d    = c - CHAR_UC_A;
                  code = LETTER_CODES[d[4:0]];
               end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
                  d    = c - CHAR_LC_A;
                  code = LETTER_CODES[d[4:0]];
               end
            end
         endcase
         return code;
      end
   endfunction

endpackage

@@ hdl/segment_lcd_text_writer_unit.sv @@
// An accepted beat waits in the input register until the emitter can load, then its
// image loads into the emitter and its first word goes out on rsp; eight result
// beats follow in order. Items are paced by the eight-beat image emission; the next
// item is taken in the cycle the last word is handed over.
// Reset clears the frame image, cursor, previous byte, bar mask and all valids.
module segment_lcd_text_writer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] word_index, [34:3] word_value, rest zero
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [3:0]  csr_wdata
);

   slcd_pkg::item_type  item_ff, item_in;
   logic                in_valid_ff, in_valid_in;
   logic [3:0]          bar_ff;
   logic                can_load;
   logic                load;
   slcd_pkg::frame_type image;
   logic [2:0]          word_index;
   logic [31:0]         word_value;

   assign load       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || load;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff && !load;
      if (req_tvalid && req_tready) begin
         item_in.op        = req_tuser;
         item_in.char_code = req_tdata;
         in_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         bar_ff      <= 4'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wen) bar_ff <= csr_wdata;
      end
   end

   slcd_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .upd      (load),
      .item     (item_ff),
      .bar_mask (bar_ff),
      .image    (image)
   );

   slcd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .image      (image),
      .can_load   (can_load),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .word_index (word_index),
      .word_value (word_value),
      .last_word  (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, word_value, word_index};

endmodule

@@ hdl/slcd_frame.sv @@
module slcd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd,
   input  slcd_pkg::item_type  item,
   input  logic [3:0]          bar_mask,
   output slcd_pkg::frame_type image
);

   slcd_pkg::frame_type frame_ff, frame_in;
   logic [2:0]  cursor_ff, cursor_in;
   logic [7:0]  prev_ff, prev_in;

   logic        is_mark;
   logic        place_ok;
   logic [2:0]  target;
   logic [15:0] code;
   logic        pos_en;

   always_comb begin
      is_mark  = !item.op && (item.char_code == slcd_pkg::CHAR_DOT ||
                              item.char_code == slcd_pkg::CHAR_COLON);
      place_ok = !(is_mark && cursor_ff == 3'd0);
      target   = is_mark ? cursor_ff - 3'd1 : cursor_ff;
      if (item.op) begin
         code = 16'h0000;
      end else if (is_mark) begin
         code = slcd_pkg::encode_byte(prev_ff) |
                ((item.char_code == slcd_pkg::CHAR_DOT) ? slcd_pkg::POINT_SEG
                                                         : slcd_pkg::COLON_SEG);
      end else begin
         code = slcd_pkg::encode_byte(item.char_code);
      end

      // scatter the code nibbles into every enabled position
      frame_in = frame_ff;
      for (int p = 0; p < slcd_pkg::NUM_DIGITS; p++) begin
         pos_en = item.op ? (3'(p) >= cursor_ff) : (place_ok && target == 3'(p));
         if (pos_en) begin
            for (int k = 0; k < 4; k++) begin
               for (int b = 0; b < 4; b++) begin
                  frame_in[3'(2 * k + int'(slcd_pkg::PIN_WORD[p][b]))]
                          [slcd_pkg::PIN_BIT[p][b]] = code[4'(12 - 4 * k + b)];
               end
            end
         end
      end

      // bars go last and override shared segment bits
      frame_in[slcd_pkg::BAR_WORD_A][slcd_pkg::BAR_BIT_LO] = bar_mask[0];
      frame_in[slcd_pkg::BAR_WORD_B][slcd_pkg::BAR_BIT_LO] = bar_mask[1];
      frame_in[slcd_pkg::BAR_WORD_A][slcd_pkg::BAR_BIT_HI] = bar_mask[2];
      frame_in[slcd_pkg::BAR_WORD_B][slcd_pkg::BAR_BIT_HI] = bar_mask[3];

      if (item.op) begin
         cursor_in = 3'd0;
         prev_in   = 8'd0;
      end else begin
         cursor_in = (is_mark || cursor_ff == 3'd7) ? cursor_ff : cursor_ff + 3'd1;
         prev_in   = item.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         cursor_ff <= 3'd0;
         prev_ff   <= 8'd0;
      end else if (upd) begin
         frame_ff  <= frame_in;
         cursor_ff <= cursor_in;
         prev_ff   <= prev_in;
      end
   end

   assign image = frame_in;

endmodule

@@ hdl/slcd_emit.sv @@
module slcd_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  slcd_pkg::frame_type image,
   output logic                can_load,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2:0]          word_index,
   output logic [31:0]         word_value,
   output logic                last_word
);

   logic [31:0] img_ff [slcd_pkg::NUM_WORDS];
   logic [31:0] img_in [slcd_pkg::NUM_WORDS];
   logic [2:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic        beat;

   assign last_word  = (idx_ff == 3'(slcd_pkg::NUM_WORDS - 1));
   assign beat       = busy_ff && out_ready;
   assign can_load   = !busy_ff || (beat && last_word);
   assign out_valid  = busy_ff;
   assign word_index = idx_ff;
   assign word_value = img_ff[0];

   always_comb begin
      img_in  = img_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         for (int i = 0; i < slcd_pkg::NUM_WORDS; i++) img_in[i] = image[i];
         idx_in  = 3'd0;
         busy_in = 1'b1;
      end else if (beat) begin
         // advance the image by one word
         for (int i = 0; i < slcd_pkg::NUM_WORDS - 1; i++) img_in[i] = img_ff[i + 1];
         idx_in  = idx_ff + 3'd1;
         busy_in = !last_word;
      end
   end

   always_ff @(posedge clock) begin
      img_ff <= img_in;
      if (reset) begin
         idx_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ test/segment_lcd_text_writer_unit_checker.sv @@
`timescale 1ns / 100ps

package slcd_tb_pkg;

   typedef enum logic {
      OP_CHAR = 1'b0,
      OP_END  = 1'b1
   } text_op_type;

endpackage

module segment_lcd_text_writer_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [2:0] word_index, [34:3] word_value, rest zero
   input  logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [3:0]  csr_wdata,
   output int          error_count,
   output int          pending_words,
   output int          items_seen,
   output int          words_seen
);

   localparam logic [15:0] ALPHA_GLYPH [26] = '{
      16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
      16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
      16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
      16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
   };

   localparam logic [15:0] NUMERAL_GLYPH [10] = '{
      16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
      16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
   };

   // bit b set: nibble bit b of that position lands in the odd word of the pair
   localparam logic [3:0] POS_ODD_WORD [6] = '{
      4'b0000, 4'b0000, 4'b0000, 4'b0110, 4'b1001, 4'b0000
   };

   localparam int POS_BIT [6][4] = '{
      '{4, 23, 22, 3}, '{6, 13, 12, 5}, '{15, 29, 28, 14},
      '{31, 1, 0, 30}, '{3, 25, 24, 2}, '{17, 8, 9, 26}
   };

   typedef struct packed {
      logic [2:0]  idx;
      logic [31:0] value;
      logic        last;
   } image_word_type;

   logic [31:0]    glass_image [slcd_pkg::NUM_WORDS];
   logic [2:0]     text_cursor;
   logic [7:0]     last_byte;
   logic [3:0]     bar_bits;
   logic [15:0]    glyph;
   image_word_type due_words [$];
   image_word_type want;
   int             n;

   function automatic logic [15:0] glyph_of(input logic [7:0] c);
      logic [15:0] g;
      logic [7:0]  d;
      g = 16'h0000;
      d = 8'h00;
      if (c >= slcd_pkg::CHAR_ZERO && c <= slcd_pkg::CHAR_NINE) begin
         d = c - slcd_pkg::CHAR_ZERO;
         g = NUMERAL_GLYPH[d[3:0]];
      end else if (c >= slcd_pkg::CHAR_UC_A && c <= slcd_pkg::CHAR_UC_Z) begin
         d = c - slcd_pkg::CHAR_UC_A;
         g = ALPHA_GLYPH[d[4:0]];
      end else begin
         case (c)
            slcd_pkg::CHAR_LC_D:  g = 16'hF300;
            slcd_pkg::CHAR_LC_M:  g = 16'hB210;
            slcd_pkg::CHAR_LC_N:  g = 16'h2210;
            slcd_pkg::CHAR_STAR:  g = 16'hA0DD;
            slcd_pkg::CHAR_LPAR:  g = 16'h0028;
            slcd_pkg::CHAR_RPAR:  g = 16'h0011;
            slcd_pkg::CHAR_MINUS: g = 16'hA000;
            slcd_pkg::CHAR_PLUS:  g = 16'hA014;
            slcd_pkg::CHAR_SLASH: g = 16'h00C0;
            slcd_pkg::CHAR_PCT:   g = 16'hB300;
            slcd_pkg::CHAR_MICRO: g = 16'h6084;
            slcd_pkg::CHAR_DEG:   g = 16'hEC00;
            slcd_pkg::CHAR_ALL:   g = 16'hFFDD;
            default: begin
               if (c >= slcd_pkg::CHAR_LC_A && c <= slcd_pkg::CHAR_LC_Z) begin
                  d = c - slcd_pkg::CHAR_LC_A;
                  g = ALPHA_GLYPH[d[4:0]];
               end
            end
         endcase
      end
      return g;
   endfunction

   // scatter the four nibbles over word pairs 0/1, 2/3, 4/5, 6/7
   task automatic paint_glyph(input logic [15:0] g, input int pos);
      logic [3:0] nib;
      int         k;
      int         b;
      int         w;
      if (pos < 0 || pos >= slcd_pkg::NUM_DIGITS) return;
      for (k = 0; k < 4; k++) begin
         nib = g[15 - 4 * k -: 4];
         for (b = 0; b < 4; b++) begin
            w = 2 * k + POS_ODD_WORD[pos][b];
            glass_image[w][POS_BIT[pos][b]] = nib[b];
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (n = 0; n < slcd_pkg::NUM_WORDS; n++) glass_image[n] = 32'h0;
         text_cursor   = 3'd0;
         last_byte     = 8'h00;
         bar_bits      = 4'h0;
         due_words.delete();
         error_count   = 0;
         pending_words = 0;
         items_seen    = 0;
         words_seen    = 0;
      end else begin
         if (csr_wen) bar_bits = csr_wdata;

         // the image of a beat accepted now cannot appear at this same edge
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (due_words.size() == 0) begin
               $error("rsp beat with no frame word pending (tdata %h)", rsp_tdata);
               error_count++;
            end else begin
               want = due_words.pop_front();
               if (rsp_tdata[2:0] !== want.idx) begin
                  $error("word_index mismatch: expected %0d, got %0d", want.idx,
                         rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tdata[34:3] !== want.value) begin
                  $error("word_value mismatch: expected %h, got %h", want.value,
                         rsp_tdata[34:3]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_word mismatch: expected %0d, got %0d", want.last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[39:35] !== 5'd0) begin
                  $error("tdata padding mismatch: expected %h, got %h", 5'd0,
                         rsp_tdata[39:35]);
                  error_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            items_seen++;
            if (req_tuser == slcd_tb_pkg::OP_END) begin
               for (n = text_cursor; n < slcd_pkg::NUM_DIGITS; n++) paint_glyph(16'h0000, n);
               text_cursor = 3'd0;
               last_byte   = 8'h00;
            end else if (req_tdata == slcd_pkg::CHAR_DOT || req_tdata == slcd_pkg::CHAR_COLON) begin
               // re-encode the byte before, with only the point or only the colon
               if (text_cursor != 3'd0) begin
                  glyph = glyph_of(last_byte)
                        | ((req_tdata == slcd_pkg::CHAR_DOT) ? slcd_pkg::POINT_SEG
                                                             : slcd_pkg::COLON_SEG);
                  paint_glyph(glyph, int'(text_cursor) - 1);
               end
               last_byte = req_tdata;
            end else begin
               paint_glyph(glyph_of(req_tdata), int'(text_cursor));
               if (text_cursor != 3'd7) text_cursor++;
               last_byte = req_tdata;
            end

            // bars go on last and win over position 5 segments on bit 8 and position 4 segments on bit 25
            glass_image[6][8]  = bar_bits[0];
            glass_image[4][8]  = bar_bits[1];
            glass_image[6][25] = bar_bits[2];
            glass_image[4][25] = bar_bits[3];

            for (n = 0; n < slcd_pkg::NUM_WORDS; n++) begin
               due_words.push_back('{idx: n[2:0], value: glass_image[n],
                                     last: (n == slcd_pkg::NUM_WORDS - 1)});
            end
         end

         pending_words = due_words.size();
      end
   end

endmodule

@@ test/segment_lcd_text_writer_unit_tb.sv @@
`timescale 1ns / 100ps

module segment_lcd_text_writer_unit_tb;

   localparam int STRING_ITEMS_PER_PHASE = 44;

   localparam slcd_pkg::item_type OPENING_TEXT [25] = '{
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_DOT},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_COLON},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_UC_A},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_DOT},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_COLON},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_LC_D},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_LC_M},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_LC_N},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_MICRO},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_DEG},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_ALL},
      {slcd_tb_pkg::OP_CHAR, 8'h00},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_UC_Z},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_DOT},
      {slcd_tb_pkg::OP_END,  8'h00},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_ZERO},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_NINE},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_STAR},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_LPAR},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_RPAR},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_MINUS},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_PLUS},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_SLASH},
      {slcd_tb_pkg::OP_CHAR, slcd_pkg::CHAR_PCT},
      {slcd_tb_pkg::OP_END,  slcd_pkg::CHAR_ALL}
   };

   localparam logic [7:0] SYMBOL_BYTES [11] = '{
      slcd_pkg::CHAR_STAR, slcd_pkg::CHAR_LPAR, slcd_pkg::CHAR_RPAR,
      slcd_pkg::CHAR_MINUS, slcd_pkg::CHAR_PLUS, slcd_pkg::CHAR_SLASH,
      slcd_pkg::CHAR_PCT, slcd_pkg::CHAR_MICRO, slcd_pkg::CHAR_DEG,
      slcd_pkg::CHAR_ALL, 8'h20
   };

   localparam logic [3:0] PHASE_BARS [4] = '{4'hF, 4'h5, 4'hA, 4'h0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_wen    = 1'b0;
   logic [3:0]  csr_wdata  = 4'h0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int error_count;
   int pending_words;
   int items_seen;
   int words_seen;
   int burst_left = 0;
   int rx_mode    = 0;
   int rx_left    = 0;
   int rx_tick    = 0;

   always #5 clock = ~clock;

   segment_lcd_text_writer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   segment_lcd_text_writer_unit_checker word_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_words (pending_words),
      .items_seen    (items_seen),
      .words_seen    (words_seen)
   );

   // receiver: switch between free flow, coin flip, periodic and heavy stall
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(16, 160);
      end else begin
         rx_left--;
      end
      rx_tick++;
      case (rx_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         2: rsp_tready = (rx_tick % 4 != 0);
         default: rsp_tready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // called at a falling edge; keep valid up within a burst
   task automatic send_text(input slcd_pkg::item_type it);
      req_tuser  = it.op;
      req_tdata  = it.char_code;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6))
            @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      wait (pending_words == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bars(input logic [3:0] v);
      csr_wen   = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   initial begin
      slcd_pkg::item_type it;
      int                 made;
      int                 len;
      int                 pick;
      int                 p;
      int                 k;
      logic [3:0]         bars;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_bars(4'h0);

      foreach (OPENING_TEXT[t]) send_text(OPENING_TEXT[t]);
      drain();

      for (p = 0; p < 5; p++) begin
         bars = (p < 4) ? PHASE_BARS[p] : 4'($urandom_range(0, 15));
         write_bars(bars);
         made = 0;
         while (made < STRING_ITEMS_PER_PHASE) begin
            len = $urandom_range(0, 9);
            for (k = 0; k < len; k++) begin
               it.op = slcd_tb_pkg::OP_CHAR;
               pick  = $urandom_range(0, 99);
               if (pick < 30) begin
                  it.char_code = slcd_pkg::CHAR_UC_A + 8'($urandom_range(0, 25));
               end else if (pick < 50) begin
                  it.char_code = slcd_pkg::CHAR_LC_A + 8'($urandom_range(0, 25));
               end else if (pick < 65) begin
                  it.char_code = slcd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
               end else if (pick < 75) begin
                  it.char_code = SYMBOL_BYTES[$urandom_range(0, 10)];
               end else if (pick < 88) begin
                  it.char_code = $urandom_range(0, 1) ? slcd_pkg::CHAR_DOT
                                                      : slcd_pkg::CHAR_COLON;
               end else begin
                  it.char_code = 8'($urandom_range(0, 255));
               end
               send_text(it);
               made++;
            end
            // most strings are terminated; the rest run on into the next one
            if ($urandom_range(0, 9) != 0) begin
               it.op        = slcd_tb_pkg::OP_END;
               it.char_code = 8'($urandom_range(0, 255));
               send_text(it);
               made++;
            end
         end
         drain();
      end

      repeat (10) @(negedge clock);
      $display("Covered %0d text items: directed glyphs, point/colon and overflow cases,",
               items_seen);
      $display("then random strings under five bar settings; %0d frame words compared.",
               words_seen);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ segment_lcd_text_writer_unit.f @@
hdl/slcd_pkg.sv
hdl/slcd_frame.sv
hdl/slcd_emit.sv
hdl/segment_lcd_text_writer_unit.sv
test/segment_lcd_text_writer_unit_checker.sv
test/segment_lcd_text_writer_unit_tb.sv
